// ----- design/rtfh_pkg.sv -----
package rtfh_pkg;

   // Partial control word held between requests.
   typedef enum logic [2:0] {
      PH_IDLE,
      PH_BS,
      PH_U,
      PH_NUM,
      PH_P,
      PH_PA,
      PH_PAR,
      PH_Q
   } phase_type;

   localparam int unsigned MAX_RESULTS = 10;
   localparam int unsigned SEG_BYTES   = 10;

   localparam logic [7:0] CH_BSL   = 8'h5C;
   localparam logic [7:0] CH_U     = 8'h75;
   localparam logic [7:0] CH_P     = 8'h70;
   localparam logic [7:0] CH_A     = 8'h61;
   localparam logic [7:0] CH_R     = 8'h72;
   localparam logic [7:0] CH_D     = 8'h64;
   localparam logic [7:0] CH_Q     = 8'h71;
   localparam logic [7:0] CH_C     = 8'h63;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_AMP   = 8'h26;
   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   // A run of output bytes; the first byte sits in the low bits.
   typedef struct packed {
      logic [3:0]              len;
      logic [SEG_BYTES*8-1:0]  bytes;
   } seg_type;

   localparam seg_type SEG_NONE    = '{len: 4'd0, bytes: '0};
   localparam seg_type SEG_BSL     = '{len: 4'd1, bytes: 80'h5C};
   localparam seg_type SEG_BSL_U   = '{len: 4'd2, bytes: 80'h755C};
   localparam seg_type SEG_BSL_P   = '{len: 4'd2, bytes: 80'h705C};
   localparam seg_type SEG_BSL_PA  = '{len: 4'd3, bytes: 80'h61705C};
   localparam seg_type SEG_BSL_Q   = '{len: 4'd2, bytes: 80'h715C};
   localparam seg_type SEG_PARA    = '{len: 4'd5, bytes: 80'h0A3E2F703C};
   localparam seg_type SEG_CENTER  = '{len: 4'd8, bytes: 80'h3E7265746E65633C};
   localparam seg_type SEG_ECENTER = '{len: 4'd9, bytes: 80'h3E7265746E65632F3C};
   localparam seg_type SEG_AMP     = '{len: 4'd5, bytes: 80'h3B706D6126};
   localparam seg_type SEG_LT      = '{len: 4'd4, bytes: 80'h3B746C26};

   function automatic logic is_digit(logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   // Signed value wrapped to 16 bits, as 1 to 3 UTF-8 bytes.
   function automatic seg_type utf8_seg(logic [15:0] mag, logic neg);
      logic [15:0] u;
      seg_type     s;
      u = neg ? (16'd0 - mag) : mag;
      s = SEG_NONE;
      if (u < 16'h0080) begin
         s.len   = 4'd1;
         s.bytes = {72'd0, u[7:0]};
      end else if (u < 16'h0800) begin
         s.len   = 4'd2;
         s.bytes = {64'd0, 2'b10, u[5:0], 3'b110, u[10:6]};
      end else begin
         s.len   = 4'd3;
         s.bytes = {56'd0, 2'b10, u[5:0], 2'b10, u[11:6], 4'b1110, u[15:12]};
      end
      return s;
   endfunction

   function automatic seg_type fresh_seg(logic [7:0] c);
      seg_type s;
      if (c == CH_AMP) begin
         s = SEG_AMP;
      end else if (c == CH_LT) begin
         s = SEG_LT;
      end else if (c == CH_BSL) begin
         s = SEG_NONE;
      end else begin
         s.len   = 4'd1;
         s.bytes = {72'd0, c};
      end
      return s;
   endfunction

   function automatic seg_type flush_seg(phase_type ph, logic [15:0] mag, logic neg);
      seg_type s;
      unique case (ph)
         PH_BS:   s = SEG_BSL;
         PH_U:    s = SEG_BSL_U;
         PH_NUM:  s = utf8_seg(mag, neg);
         PH_P:    s = SEG_BSL_P;
         PH_PA:   s = SEG_BSL_PA;
         PH_PAR:  s = SEG_PARA;
         PH_Q:    s = SEG_BSL_Q;
         default: s = SEG_NONE;
      endcase
      return s;
   endfunction

   function automatic seg_type seg_cat(seg_type a, seg_type b);
      seg_type s;
      s.len   = a.len + b.len;
      s.bytes = a.bytes | (b.bytes << {a.len, 3'b000});
      return s;
   endfunction

endpackage

// ----- design/rtfh_if.sv -----
interface rtfh_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_text;

   modport source (output valid, output in_byte, output end_of_text, input ready);
   modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

interface rtfh_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       byte_valid;
   logic       last_of_text;

   modport source (output valid, output out_byte, output byte_valid, output last_of_text,
                   input ready);
   modport sink   (input valid, input out_byte, input byte_valid, input last_of_text,
                   output ready);
endinterface

// ----- design/rtf_to_html_byte_filter_core.sv -----
// Channel   Direction  Payload
// req_if    in         in_byte[7:0], end_of_text
// rsp_if    out        out_byte[7:0], byte_valid, last_of_text
//
// A request is decoded in the cycle it is accepted and its whole expansion (0 to 10
// bytes) lands in one result register, which then hands out one byte per cycle while
// rsp_if is ready. A request that yields several bytes holds the result register until
// they have all left; requests that yield one byte or none stream at one per cycle.
// The next request is taken while the last pending byte leaves.
// Reset is synchronous and clears the match state, centering flag and result count.
// A stalled rsp_if holds the current byte and blocks req_if once it is the last one.
module rtf_to_html_byte_filter_core (
   input  logic       clock,
   input  logic       reset,
   rtfh_req_if.sink   req_if,
   rtfh_rsp_if.source rsp_if
);
   import rtfh_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [15:0] number_ff, number_in;
   logic        negative_ff, negative_in;
   logic        center_ff, center_in;

   logic [SEG_BYTES*8-1:0] buf_ff, buf_in;
   logic [3:0]             count_ff, count_in;
   logic                   last_ff, last_in;
   logic                   marker_ff, marker_in;

   logic       req_fire;
   logic       rsp_fire;
   logic [7:0] c;
   logic       eot;
   logic       do_fresh;
   seg_type    seg_head, seg_fresh, seg_flush, seg_all;

   assign c   = req_if.in_byte;
   assign eot = req_if.end_of_text;

   assign req_if.ready = (count_ff == 4'd0) || ((count_ff == 4'd1) && rsp_if.ready);
   assign req_fire     = req_if.valid && req_if.ready;
   assign rsp_fire     = rsp_if.valid && rsp_if.ready;

   assign rsp_if.valid        = (count_ff != 4'd0);
   assign rsp_if.out_byte     = buf_ff[7:0];
   assign rsp_if.byte_valid   = !marker_ff;
   assign rsp_if.last_of_text = last_ff && (count_ff == 4'd1);

   always_comb begin
      phase_in    = PH_IDLE;
      number_in   = number_ff;
      negative_in = negative_ff;
      center_in   = center_ff;
      seg_head    = SEG_NONE;
      seg_fresh   = SEG_NONE;
      seg_flush   = SEG_NONE;
      do_fresh    = 1'b0;

      unique case (phase_ff)
         PH_BS: begin
            if (c == CH_U) begin
               phase_in = PH_U;
            end else if (c == CH_P) begin
               phase_in = PH_P;
            end else if (c == CH_Q) begin
               phase_in = PH_Q;
            end else begin
               seg_head = SEG_BSL;
               do_fresh = 1'b1;
            end
         end
         PH_U: begin
            if ((c == CH_MINUS) || is_digit(c)) begin
               negative_in = (c == CH_MINUS);
               number_in   = (c == CH_MINUS) ? 16'd0 : {12'd0, c[3:0]};
               phase_in    = PH_NUM;
            end else begin
               seg_head = SEG_BSL_U;
               do_fresh = 1'b1;
            end
         end
         PH_NUM: begin
            if (is_digit(c)) begin
               number_in = (number_ff << 3) + (number_ff << 1) + {12'd0, c[3:0]};
               phase_in  = PH_NUM;
            end else begin
               // The byte that ends the number is dropped.
               seg_head = utf8_seg(number_ff, negative_ff);
            end
         end
         PH_P: begin
            if (c == CH_A) begin
               phase_in = PH_PA;
            end else begin
               seg_head = SEG_BSL_P;
               do_fresh = 1'b1;
            end
         end
         PH_PA: begin
            if (c == CH_R) begin
               phase_in = PH_PAR;
            end else begin
               seg_head = SEG_BSL_PA;
               do_fresh = 1'b1;
            end
         end
         PH_PAR: begin
            if (c == CH_D) begin
               if (center_ff) begin
                  seg_head  = SEG_ECENTER;
                  center_in = 1'b0;
               end
            end else begin
               seg_head = SEG_PARA;
               do_fresh = 1'b1;
            end
         end
         PH_Q: begin
            if (c == CH_C) begin
               if (!center_ff) begin
                  seg_head  = SEG_CENTER;
                  center_in = 1'b1;
               end
            end else begin
               seg_head = SEG_BSL_Q;
               do_fresh = 1'b1;
            end
         end
         default: begin
            do_fresh = 1'b1;
         end
      endcase

      if (do_fresh) begin
         seg_fresh = fresh_seg(c);
         if (c == CH_BSL) begin
            phase_in = PH_BS;
         end
      end

      // At end of text whatever is still held goes out, and the state starts over.
      if (eot) begin
         seg_flush   = flush_seg(phase_in, number_in, negative_in);
         phase_in    = PH_IDLE;
         number_in   = 16'd0;
         negative_in = 1'b0;
         center_in   = 1'b0;
      end

      seg_all = seg_cat(seg_cat(seg_head, seg_fresh), seg_flush);
   end

   always_comb begin
      buf_in    = buf_ff;
      count_in  = count_ff;
      last_in   = last_ff;
      marker_in = marker_ff;
      if (req_fire) begin
         if (eot && (seg_all.len == 4'd0)) begin
            buf_in    = '0;
            count_in  = 4'd1;
            last_in   = 1'b1;
            marker_in = 1'b1;
         end else begin
            buf_in    = seg_all.bytes;
            count_in  = seg_all.len;
            last_in   = eot;
            marker_in = 1'b0;
         end
      end else if (rsp_fire) begin
         buf_in   = buf_ff >> 8;
         count_in = count_ff - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         number_ff   <= 16'd0;
         negative_ff <= 1'b0;
         center_ff   <= 1'b0;
         count_ff    <= 4'd0;
         last_ff     <= 1'b0;
         marker_ff   <= 1'b0;
      end else begin
         if (req_fire) begin
            phase_ff    <= phase_in;
            number_ff   <= number_in;
            negative_ff <= negative_in;
            center_ff   <= center_in;
         end
         count_ff  <= count_in;
         last_ff   <= last_in;
         marker_ff <= marker_in;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 4'(MAX_RESULTS))
      else $error("result register holds more bytes than one request can yield");

   a_marker_alone: assert property (@(posedge clock) disable iff (reset)
      (marker_ff && (count_ff != 4'd0)) |-> (count_ff == 4'd1) && last_ff)
      else $error("empty end marker is not a lone final result");

   a_eot_clears: assert property (@(posedge clock) disable iff (reset)
      (req_fire && eot) |=> (phase_ff == PH_IDLE) && !center_ff && (number_ff == 16'd0)
         && !negative_ff)
      else $error("state not returned to start after end of text");

   a_eot_delivers: assert property (@(posedge clock) disable iff (reset)
      (req_fire && eot) |=> (count_ff != 4'd0) && last_ff)
      else $error("end of text produced no final result");

   a_ready_drain: assert property (@(posedge clock) disable iff (reset)
      req_if.ready |-> (count_ff <= 4'd1))
      else $error("request taken while earlier bytes are still pending");

endmodule
